// ===== rtl/d128_pkg.sv =====
// Package for the 128-by-64 divider: payload structs, status codes, pipeline geometry.
// No dependencies.
`default_nettype none
package d128_pkg;

    localparam int unsigned WordW      = 64;
    localparam int unsigned BitsPerStg = 8;
    localparam int unsigned NumDivStg  = WordW / BitsPerStg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [63:0] dividend_high;
        logic [63:0] dividend_low;
        logic [63:0] divisor;
        logic        signed_mode;
    } div_in_t;

    typedef struct packed {
        logic [63:0] quotient;
        logic [63:0] remainder;
        logic [1:0]  status;
    } div_out_t;

    // Operand record carried through the restoring-division stages.
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] lo;
        logic [63:0] d;
        logic [63:0] q;
        logic        qneg;
        logic        nneg;
        logic        sgn;
        logic [1:0]  status;
    } div_work_t;

endpackage
`default_nettype wire

// ===== rtl/divide_128_by_64_core.sv =====
// Top level of the pipelined 128-by-64 divider (divq / idivq semantics with status).
// Depends on d128_pkg.
//
//   channel | direction | ports                         | payload
//   s_      | in        | s_valid, s_ready, s_data      | div_in_t
//   m_      | out       | m_valid, m_ready, m_data      | div_out_t
//
// Eleven register stages: a sign/magnitude stage, eight restoring stages of
// eight quotient bits each, a sign fix-up stage and the output register.
// One transaction enters per cycle while the pipe advances. The whole pipe
// advances together and holds while the output register is full and not
// taken. Reset clears the valid bits only.
`default_nettype none
module divide_128_by_64_core
    import d128_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire div_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output div_out_t      m_data
);

    logic advance;
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    // Front stage: magnitudes and early error checks.
    logic        nneg, dneg;
    logic [63:0] ah, al, ad;
    logic [1:0]  pre_status;
    div_work_t   front_next;

    always_comb begin
        nneg = s_data.signed_mode && s_data.dividend_high[63];
        dneg = s_data.signed_mode && s_data.divisor[63];
        al   = nneg ? (~s_data.dividend_low + 64'd1) : s_data.dividend_low;
        ah   = nneg ? (~s_data.dividend_high + {63'd0, s_data.dividend_low == 64'd0})
                    : s_data.dividend_high;
        ad   = dneg ? (~s_data.divisor + 64'd1) : s_data.divisor;
        if (s_data.divisor == 64'd0) begin
            pre_status = ST_DIV_ZERO;
        end else if (ah >= ad) begin
            pre_status = ST_OVERFLOW;
        end else begin
            pre_status = ST_OK;
        end
        front_next.rem    = ah;
        front_next.lo     = al;
        front_next.d      = ad;
        front_next.q      = '0;
        front_next.qneg   = nneg ^ dneg;
        front_next.nneg   = nneg;
        front_next.sgn    = s_data.signed_mode;
        front_next.status = pre_status;
    end

    div_work_t stage_reg [NumDivStg+1];
    logic      vld_reg   [NumDivStg+1];
    div_work_t stage_next [NumDivStg+1];

    // Each stage retires BitsPerStg quotient bits.
    always_comb begin
        stage_next[0] = front_next;
        for (int s = 1; s <= NumDivStg; s++) begin
            div_work_t w;
            logic      top;
            w = stage_reg[s-1];
            for (int b = 0; b < BitsPerStg; b++) begin
                top   = w.rem[63];
                w.rem = {w.rem[62:0], w.lo[63]};
                w.lo  = {w.lo[62:0], 1'b0};
                w.q   = {w.q[62:0], 1'b0};
                if (top || w.rem >= w.d) begin
                    w.rem  = w.rem - w.d;
                    w.q[0] = 1'b1;
                end
            end
            stage_next[s] = w;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int s = 0; s <= NumDivStg; s++) begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= NumDivStg; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (advance) begin
            vld_reg[0] <= s_valid;
            for (int s = 1; s <= NumDivStg; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Fix-up: signed range check and sign restore.
    div_work_t fin;
    div_out_t  out_next;
    logic      sovf;
    always_comb begin
        fin  = stage_reg[NumDivStg];
        sovf = fin.sgn && ((!fin.qneg && fin.q[63]) ||
                           (fin.qneg && fin.q[63] && (fin.q[62:0] != 63'd0)));
        if (fin.status != ST_OK) begin
            out_next = '{quotient: '0, remainder: '0, status: fin.status};
        end else if (sovf) begin
            out_next = '{quotient: '0, remainder: '0, status: ST_OVERFLOW};
        end else begin
            out_next.quotient  = fin.qneg ? (~fin.q + 64'd1) : fin.q;
            out_next.remainder = fin.nneg ? (~fin.rem + 64'd1) : fin.rem;
            out_next.status    = ST_OK;
        end
    end

    div_out_t fix_reg;
    logic     fix_vld_reg;

    always_ff @(posedge aclk) begin
        if (advance) begin
            fix_reg <= out_next;
            m_data  <= fix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fix_vld_reg <= 1'b0;
            m_valid     <= 1'b0;
        end else if (advance) begin
            fix_vld_reg <= vld_reg[NumDivStg];
            m_valid     <= fix_vld_reg;
        end
    end

endmodule
`default_nettype wire

// ===== dv/tb_divide_128_by_64_core.sv =====
// Self-checking bench for the pipelined 128-by-64 divider: random and corner operand sets
// against a bit-level divq/idivq predictor. Depends on d128_pkg and divide_128_by_64_core.
`default_nettype none
module tb_divide_128_by_64_core;
    timeunit 1ns;
    timeprecision 1ps;
    import d128_pkg::*;

    class quotient_board;
        div_out_t pending[$];
        int unsigned mismatches;
        int unsigned checked;

        // Unsigned restoring division; caller guarantees hi < d, d != 0.
        function automatic void udivide(input logic [63:0] hi, input logic [63:0] lo,
                                        input logic [63:0] d,
                                        output logic [63:0] q, output logic [63:0] r);
            logic [64:0] acc;
            acc = {1'b0, hi};
            q = '0;
            for (int i = 63; i >= 0; i--) begin
                acc = {acc[63:0], lo[i]};
                q = q << 1;
                if (acc >= {1'b0, d}) begin
                    acc = acc - {1'b0, d};
                    q[0] = 1'b1;
                end
            end
            r = acc[63:0];
        endfunction

        function automatic div_out_t predict_division(input div_in_t x);
            div_out_t o;
            logic [127:0] mag_n;
            logic [63:0] mag_d, mq, mr;
            logic qneg;
            o = '0;
            o.status = ST_OK;
            if (x.divisor == 0) begin
                o.status = ST_DIV_ZERO;
            end else if (!x.signed_mode) begin
                if (x.dividend_high >= x.divisor) o.status = ST_OVERFLOW;
                else udivide(x.dividend_high, x.dividend_low, x.divisor,
                             o.quotient, o.remainder);
            end else begin
                mag_n = {x.dividend_high, x.dividend_low};
                if (mag_n[127]) mag_n = -mag_n;
                mag_d = x.divisor[63] ? -x.divisor : x.divisor;
                qneg = x.dividend_high[63] ^ x.divisor[63];
                if (mag_n[127:64] >= mag_d) begin
                    o.status = ST_OVERFLOW;
                end else begin
                    udivide(mag_n[127:64], mag_n[63:0], mag_d, mq, mr);
                    if ((!qneg && mq[63]) || (qneg && mq > 64'h8000_0000_0000_0000))
                        o.status = ST_OVERFLOW;
                    else begin
                        o.quotient = qneg ? -mq : mq;
                        o.remainder = x.dividend_high[63] ? -mr : mr;
                    end
                end
            end
            return o;
        endfunction

        function void note_operands(input div_in_t x);
            pending.push_back(predict_division(x));
        endfunction

        function void check_result(input div_out_t got);
            div_out_t want;
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.quotient !== want.quotient || got.remainder !== want.remainder ||
                got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp q=%h r=%h st=%0d got q=%h r=%h st=%0d",
                             want.quotient, want.remainder, want.status,
                             got.quotient, got.remainder, got.status);
            end
        endfunction
    endclass

    localparam int unsigned Latency = 11;
    localparam int unsigned IdleLimit = 20000;

    logic aclk, aresetn, s_valid, s_ready, m_valid, m_ready;
    div_in_t s_data;
    div_out_t m_data;
    quotient_board board;
    int unsigned send_idle_pct, recv_stall_pct, idle_cycles, sent;

    divide_128_by_64_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Check outputs and note inputs at the edge; the watchdog counts dead cycles.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) board.check_result(m_data);
            if (s_valid && s_ready) board.note_operands(s_data);
            if ((m_valid && m_ready) || (s_valid && s_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [63:0] rand_word();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return {1'b1, 63'd0};
            3: return {1'b0, {63{1'b1}}};
            4: return 64'($urandom_range(16));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Mostly in-range divisions: high kept below divisor when unsigned, shrunk when signed.
    function automatic div_in_t random_operands();
        div_in_t x;
        x.signed_mode = 1'($urandom_range(1));
        x.divisor = rand_word();
        x.dividend_low = rand_word();
        if ($urandom_range(9) < 7 && x.divisor != 0) begin
            x.dividend_high = {$urandom(), $urandom()} >> $urandom_range(63, 1);
            if (x.signed_mode) begin
                x.dividend_high = x.dividend_high >> 1;
                if ($urandom_range(1)) x.dividend_high = ~x.dividend_high;
            end else if (x.dividend_high >= x.divisor) begin
                x.dividend_high = x.dividend_high % x.divisor;
            end
        end else begin
            x.dividend_high = rand_word();
        end
        return x;
    endfunction

    task automatic send_operands(input div_in_t x);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic go_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    function automatic div_in_t operands(input logic [63:0] h, input logic [63:0] l,
                                         input logic [63:0] d, input logic s);
        div_in_t x;
        x.dividend_high = h;
        x.dividend_low = l;
        x.divisor = d;
        x.signed_mode = s;
        return x;
    endfunction

    initial begin
        int unsigned drain;
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Corners: zero divisor, overflow both modes, most negative values, -2^63 quotient.
        send_operands(operands(0, 0, 0, 0));
        send_operands(operands('1, '1, 0, 1));
        send_operands(operands(5, 0, 5, 0));
        send_operands(operands('1, '1, '1, 0));
        send_operands(operands(64'hFFFF_FFFF_FFFF_FFFE, '1, '1, 0));
        send_operands(operands(0, '1, 1, 0));
        send_operands(operands(0, 0, 1, 0));
        send_operands(operands({1'b1, 63'd0}, 0, 1, 1));
        send_operands(operands('1, {1'b1, 63'd0}, 1, 1));
        send_operands(operands('1, {1'b1, 63'd0}, '1, 1));
        send_operands(operands(0, {1'b1, 63'd0}, '1, 1));
        send_operands(operands(0, {1'b0, {63{1'b1}}}, 1, 1));
        send_operands(operands('1, '1, 2, 1));
        send_operands(operands('1, 64'hFFFF_FFFF_FFFF_FFF9, 2, 1));
        send_operands(operands(0, 7, 64'hFFFF_FFFF_FFFF_FFFE, 1));
        send_operands(operands('1, 0, {1'b1, 63'd0}, 1));
        send_operands(operands(64'h1234, '1, '1, 1));
        send_operands(operands(64'h0FFF_FFFF_FFFF_FFFF, '1, {1'b0, {63{1'b1}}}, 0));
        // Hold off until the pipe has drained once.
        go_quiet();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            repeat (375) send_operands(random_operands());
        end
        s_valid <= 1'b0;
        drain = 0;
        while (board.pending.size() != 0 && drain < IdleLimit) begin
            @(posedge aclk);
            drain++;
        end
        repeat (Latency + 4) @(posedge aclk);
        $display("covered %0d operand sets, %0d results checked, unsigned and signed,",
                 sent, board.checked);
        $display("with corner operands and four sender/receiver stall mixes");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
